>>> rtl/srng_pkg.sv
// ----------------------------------------------------------------------------
// Subtractive lagged generator package
// Shared constants, the controller state type, the table access request and
// the modular subtract used by the table build and by every draw.
// ----------------------------------------------------------------------------
package srng_pkg;

  localparam int unsigned ValueW  = 30;
  localparam int unsigned SeedW   = 31;
  localparam int unsigned AddrW   = 6;
  localparam int unsigned Entries = 56;

  localparam logic [ValueW-1:0] Modulus     = 30'd990000000;
  localparam logic [SeedW-1:0]  ModulusWide = 31'd990000000;
  localparam logic [SeedW-1:0]  SeedBase    = 31'd161803398;
  localparam logic [AddrW-1:0]  Stride      = 6'd21;
  localparam logic [AddrW-1:0]  TableLen    = 6'd55;
  localparam logic [AddrW-1:0]  LagOffset   = 6'd31;
  localparam logic [AddrW-1:0]  WrapPoint   = 6'd56;
  localparam logic [AddrW-1:0]  SpreadLast  = 6'd54;
  localparam logic [AddrW-1:0]  PartnerEdge = 6'd24;
  localparam logic [1:0]        LastPass    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED,
    S_REDUCE,
    S_SPREAD,
    S_WARM_RD,
    S_WARM_WR,
    S_DRAW_RD,
    S_DRAW_WR
  } state_t;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [ValueW-1:0] wdata;
    logic [AddrW-1:0]  raddr_a;
    logic [AddrW-1:0]  raddr_b;
  } mem_req_t;

  // (a - b) mod Modulus for operands already below the modulus.
  function automatic logic [ValueW-1:0] sub_mod(input logic [ValueW-1:0] a,
                                                input logic [ValueW-1:0] b);
    logic [ValueW:0] sum;
    begin
      sum = {1'b0, a} + {1'b0, Modulus} - {1'b0, b};
      if (a >= b) begin
        sub_mod = a - b;
      end else begin
        sub_mod = sum[ValueW-1:0];
      end
    end
  endfunction

  function automatic logic [AddrW-1:0] advance(input logic [AddrW-1:0] p);
    logic [AddrW-1:0] q;
    begin
      q = p + 6'd1;
      if (q >= WrapPoint) begin
        advance = 6'd1;
      end else begin
        advance = q;
      end
    end
  endfunction

endpackage

>>> rtl/subtractive_lagged_rng_core.sv
// ----------------------------------------------------------------------------
// Subtractive lagged random generator core
// A plain draw passes the read and write-back states before random_value is
// registered; the write-back waits while the output register is full, and no
// new draw is taken until the sequencer is back in idle. A build (reseed, or
// first draw after reset) runs the seed and reduce states, 54 spread writes and
// four warm-up passes of 55 read and write-back steps each before that draw.
// Reset: synchronous; seed becomes 1, the table is marked unbuilt.
// ----------------------------------------------------------------------------
//
// Each draw asks for one value of the subtractive generator. The 55 entry
// lag table lives in a synchronous memory with two registered read ports and
// one write port. A draw reads the entries at both advanced pointers, then
// writes their modular difference back at the first pointer in the write-back
// state, so accesses to one entry never overlap and no forwarding is needed.
// The table is built lazily: the first transaction after reset, and any
// transaction with reseed set, rebuilds it from the seed register first.
// The memory contents are not cleared by reset because the build writes
// every entry before any read.
//
// The result sits in an output register, so the core can accept the next
// transaction while a finished value still waits for the downstream side.
// The seed register may be written at any time the core is idle; it only
// takes effect at the next build.
module subtractive_lagged_rng_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srng_pkg::SeedW-1:0]    seed_magnitude,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          reseed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srng_pkg::ValueW-1:0]   random_value
);

  logic [srng_pkg::SeedW-1:0]  seed_value;
  srng_pkg::mem_req_t          req;
  logic [srng_pkg::ValueW-1:0] rdata_a;
  logic [srng_pkg::ValueW-1:0] rdata_b;
  logic                        idle;
  logic                        out_free;
  logic                        result_load;
  logic [srng_pkg::ValueW-1:0] result_value;

  // The seed register always takes a configuration transaction.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= 31'd1;
    end else if (cfg_valid) begin
      seed_value <= seed_magnitude;
    end
  end

  // An input transaction is taken whenever the sequencer is idle.
  assign in_ready = idle;

  // The output register is free when empty or being emptied this cycle.
  assign out_free = !out_valid || out_ready;

  srng_lag_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  srng_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (in_valid),
    .reseed       (reseed),
    .seed_value   (seed_value),
    .out_free     (out_free),
    .rdata_a      (rdata_a),
    .rdata_b      (rdata_b),
    .idle         (idle),
    .req          (req),
    .result_load  (result_load),
    .result_value (result_value)
  );

  // Output register: valid is control state, the value is plain payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      random_value <= result_value;
    end
  end

endmodule

>>> rtl/srng_lag_mem.sv
// ----------------------------------------------------------------------------
// Lag table memory
// Synchronous memory with one write port and two read ports; read data is
// registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module srng_lag_mem (
  input  logic                          clk,
  input  srng_pkg::mem_req_t            req,
  output logic [srng_pkg::ValueW-1:0]   rdata_a,
  output logic [srng_pkg::ValueW-1:0]   rdata_b
);

  logic [srng_pkg::ValueW-1:0] mem [srng_pkg::Entries];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[req.raddr_a];
    rdata_b <= mem[req.raddr_b];
  end

endmodule

>>> rtl/srng_ctrl.sv
// ----------------------------------------------------------------------------
// Generator sequencer
// Builds the lag table from the seed, warms it in four passes and performs
// draws by read, subtract and write-back through the lag table memory.
// ----------------------------------------------------------------------------
module srng_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          reseed,
  input  logic [srng_pkg::SeedW-1:0]    seed_value,
  input  logic                          out_free,
  input  logic [srng_pkg::ValueW-1:0]   rdata_a,
  input  logic [srng_pkg::ValueW-1:0]   rdata_b,
  output logic                          idle,
  output srng_pkg::mem_req_t            req,
  output logic                          result_load,
  output logic [srng_pkg::ValueW-1:0]   result_value
);

  srng_pkg::state_t state, state_next;

  logic                          table_ready;
  logic [srng_pkg::AddrW-1:0]    first_ptr;
  logic [srng_pkg::AddrW-1:0]    second_ptr;
  logic [srng_pkg::SeedW-1:0]    start_val;
  logic [srng_pkg::ValueW-1:0]   chain_prev;
  logic [srng_pkg::ValueW-1:0]   chain_next;
  logic [srng_pkg::AddrW-1:0]    slot;
  logic [srng_pkg::AddrW-1:0]    count;
  logic [srng_pkg::AddrW-1:0]    idx;
  logic [1:0]                    pass;

  logic [srng_pkg::AddrW-1:0]    partner;
  logic [srng_pkg::AddrW:0]      slot_sum;
  logic [srng_pkg::AddrW-1:0]    draw_a;
  logic [srng_pkg::AddrW-1:0]    draw_b;
  logic [srng_pkg::ValueW-1:0]   diff_val;

  assign diff_val = srng_pkg::sub_mod(rdata_a, rdata_b);
  assign draw_a   = srng_pkg::advance(first_ptr);
  assign draw_b   = srng_pkg::advance(second_ptr);
  assign slot_sum = {1'b0, slot} + {1'b0, srng_pkg::Stride};

  // Warm-up partner of entry i is 1 + ((i + 30) mod 55).
  always_comb begin
    if (idx <= srng_pkg::PartnerEdge) begin
      partner = idx + srng_pkg::LagOffset;
    end else begin
      partner = idx - srng_pkg::PartnerEdge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srng_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    idle         = 1'b0;
    result_load  = 1'b0;
    result_value = diff_val;
    req.we       = 1'b0;
    req.waddr    = idx;
    req.wdata    = diff_val;
    req.raddr_a  = idx;
    req.raddr_b  = partner;
    case (state)
      srng_pkg::S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          if (reseed || !table_ready) begin
            state_next = srng_pkg::S_SEED;
          end else begin
            state_next = srng_pkg::S_DRAW_RD;
          end
        end
      end
      srng_pkg::S_SEED: begin
        state_next = srng_pkg::S_REDUCE;
      end
      srng_pkg::S_REDUCE: begin
        if (start_val < srng_pkg::ModulusWide) begin
          req.we     = 1'b1;
          req.waddr  = srng_pkg::TableLen;
          req.wdata  = start_val[srng_pkg::ValueW-1:0];
          state_next = srng_pkg::S_SPREAD;
        end
      end
      srng_pkg::S_SPREAD: begin
        req.we    = 1'b1;
        req.waddr = slot;
        req.wdata = chain_next;
        if (count == srng_pkg::SpreadLast) begin
          state_next = srng_pkg::S_WARM_RD;
        end
      end
      srng_pkg::S_WARM_RD: begin
        state_next = srng_pkg::S_WARM_WR;
      end
      srng_pkg::S_WARM_WR: begin
        req.we = 1'b1;
        if (idx == srng_pkg::TableLen && pass == srng_pkg::LastPass) begin
          state_next = srng_pkg::S_DRAW_RD;
        end else begin
          state_next = srng_pkg::S_WARM_RD;
        end
      end
      srng_pkg::S_DRAW_RD: begin
        req.raddr_a = draw_a;
        req.raddr_b = draw_b;
        state_next  = srng_pkg::S_DRAW_WR;
      end
      srng_pkg::S_DRAW_WR: begin
        // Keep reading the draw entries so the operands hold while stalled.
        req.raddr_a = first_ptr;
        req.raddr_b = second_ptr;
        req.waddr   = first_ptr;
        if (out_free) begin
          req.we      = 1'b1;
          result_load = 1'b1;
          state_next  = srng_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = srng_pkg::S_IDLE;
      end
    endcase
  end

  // Control state that must be known after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_ready <= 1'b0;
      first_ptr   <= '0;
      second_ptr  <= srng_pkg::LagOffset;
    end else begin
      case (state)
        srng_pkg::S_WARM_WR: begin
          if (idx == srng_pkg::TableLen && pass == srng_pkg::LastPass) begin
            table_ready <= 1'b1;
            first_ptr   <= '0;
            second_ptr  <= srng_pkg::LagOffset;
          end
        end
        srng_pkg::S_DRAW_RD: begin
          first_ptr  <= draw_a;
          second_ptr <= draw_b;
        end
        default: begin
        end
      endcase
    end
  end

  // Build datapath; these registers are always loaded before they are used.
  always_ff @(posedge clk) begin
    case (state)
      srng_pkg::S_SEED: begin
        if (seed_value >= srng_pkg::SeedBase) begin
          start_val <= seed_value - srng_pkg::SeedBase;
        end else begin
          start_val <= srng_pkg::SeedBase - seed_value;
        end
      end
      srng_pkg::S_REDUCE: begin
        if (start_val >= srng_pkg::ModulusWide) begin
          start_val <= start_val - srng_pkg::ModulusWide;
        end else begin
          chain_prev <= start_val[srng_pkg::ValueW-1:0];
          chain_next <= {{(srng_pkg::ValueW-1){1'b0}}, 1'b1};
          slot       <= srng_pkg::Stride;
          count      <= 6'd1;
        end
      end
      srng_pkg::S_SPREAD: begin
        chain_next <= srng_pkg::sub_mod(chain_prev, chain_next);
        chain_prev <= chain_next;
        if (slot_sum >= {1'b0, srng_pkg::TableLen}) begin
          slot <= slot_sum[srng_pkg::AddrW-1:0] - srng_pkg::TableLen;
        end else begin
          slot <= slot_sum[srng_pkg::AddrW-1:0];
        end
        count <= count + 6'd1;
        idx   <= 6'd1;
        pass  <= 2'd0;
      end
      srng_pkg::S_WARM_WR: begin
        if (idx == srng_pkg::TableLen) begin
          idx  <= 6'd1;
          pass <= pass + 2'd1;
        end else begin
          idx <= idx + 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // A table write never lands on the unused entry zero or beyond entry 55.
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    req.we |-> (req.waddr != 6'd0 && req.waddr <= srng_pkg::TableLen))
    else $error("lag table write outside entries 1..55");

  // The two pointers keep a lag of 31 modulo 55.
  a_ptr_lag: assert property (@(posedge clk) disable iff (rst)
    (second_ptr == first_ptr + srng_pkg::LagOffset) ||
    (first_ptr == second_ptr + srng_pkg::PartnerEdge))
    else $error("pointer lag lost");

  // A draw only completes into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    result_load |-> out_free)
    else $error("result loaded into an occupied output register");

  // A draw always follows a built table.
  a_draw_ready: assert property (@(posedge clk) disable iff (rst)
    (state == srng_pkg::S_DRAW_WR) |-> table_ready)
    else $error("draw from an unbuilt table");

endmodule
